// ===== rtl/lcw_pkg.sv =====
// Shared types, constants and helper functions of the LED color wobble generator.
package lcw_pkg;

    // Default parameter values
    localparam int BANKS_DEF      = 4;
    localparam int LEVEL_BITS_DEF = 12;

    // At most this many banks are emitted per tick
    localparam int MAX_RESULTS = 4;

    // Field widths fixed by the stream format
    localparam int FIELD_W = 12;

    // Pipeline geometry: sine unit latency, table stage, last stage
    localparam int SINE_LAT   = 5;
    localparam int TAB_STAGE  = 2 * SINE_LAT;
    localparam int PIPE_DEPTH = TAB_STAGE + 1;

    // Tick counter and inner phase accumulator (count * 4096 / 125)
    localparam logic [17:0] TICK_LAST   = 18'd199999;
    localparam logic [17:0] TICK_WRAP   = 18'd200000;
    localparam logic [6:0]  PH_DEN      = 7'd125;
    localparam logic [6:0]  PH_REM_STEP = 7'd96;
    localparam logic [15:0] PH_STEP     = 16'd32;

    // Per-bank inner phase offset, 104304 reduced to a 16-bit turn fraction
    localparam logic [15:0] BANK_PHASE = 16'd38768;

    // Sine polynomial coefficients (Q14 input, Q15 output)
    localparam logic [15:0] SIN_C1  = 16'd51472;
    localparam logic [14:0] SIN_C3  = 15'd21023;
    localparam logic [11:0] SIN_C5  = 12'd2320;
    localparam logic [14:0] QTR     = 15'd16384;
    localparam logic [14:0] Q15_MAX = 15'h7FFF;

    // Item kinds carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_MAX_LEVEL = 1'b0;
    localparam logic CFG_MIN_LEVEL = 1'b1;

    // Write check result codes
    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_HIGH = 2'd1,
        ERR_LOW  = 2'd2
    } err_t;

    // Table access for one color lane at the table stage
    typedef struct packed {
        logic               we;
        logic [1:0]         bank;
        logic [FIELD_W-1:0] amp;
        logic [FIELD_W-1:0] off;
    } tab_t;

    // Per-stage control carried alongside the datapath
    typedef struct packed {
        logic               op;
        logic [1:0]         bank;
        logic               last;
        logic [1:0]         color;
        logic [FIELD_W-1:0] amp;
        logic [FIELD_W-1:0] off;
        err_t               err;
        logic               store;
    } meta_t;

    // Outer phase offset per color: 0 red, 1/3 turn green and white, 2/3 blue
    function automatic logic [15:0] color_phase(input logic [1:0] color);
        logic [15:0] ph;
        unique case (color)
            2'd0:    ph = 16'd0;
            2'd1:    ph = 16'd21845;
            2'd2:    ph = 16'd43691;
            default: ph = 16'd21845;
        endcase
        return ph;
    endfunction

endpackage

// ===== rtl/led_color_wobble_generator.sv =====
// Top level of the LED color wobble generator: issue, inner sine, color lanes, merge.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  s_      | in  | s_tvalid / s_tready    | s_tuser op, s_tdata write/tick fields
//  m_      | out | m_tvalid / m_tready    | m_tdata bank and levels, m_tlast
//  cfg_    | in  | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// A write item issues once; a tick with emit set issues
// min(BANKS,4) banks, one per cycle while the output is not stalled; a tick without
// emit issues nothing. The issue stage is the rate limit; from issue to the
// output register lie two 5-stage sine units and one multiply stage.
// Reset clears tables, counter and all valid bits. m_tready low while a result
// is held freezes the pipeline; new items wait until the issue stage frees.
module led_color_wobble_generator import lcw_pkg::*; #(
    parameter int BANKS      = BANKS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // bank_sel[1:0] color_sel[3:2] amplitude_in[15:4]
                                          // offset_in[27:16] emit[28]
    input  logic               s_tuser,   // op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata,   // bank_out[1:0] red_level[13:2] green_level[25:14]
                                          // blue_level[37:26] white_level[49:38]
                                          // write_error[51:50]
    output logic               m_tlast,   // last
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [FIELD_W-1:0] cfg_wdata
);

    localparam int EMIT_BANKS = (BANKS < MAX_RESULTS) ? BANKS : MAX_RESULTS;
    localparam logic [1:0] LAST_BANK = 2'(EMIT_BANKS - 1);

    // Configuration
    logic [FIELD_W-1:0] max_level_reg, min_level_reg;

    // Tick counter and phase accumulator
    logic [17:0] tick_cnt_reg, tick_cnt_next;
    logic [15:0] ph_q_reg, ph_q_next;
    logic [6:0]  ph_rem_reg, ph_rem_next;

    // Issue stage and pipeline control
    logic            iss_vld_reg, iss_vld_next;
    meta_t           iss_reg, iss_next;
    logic [PIPE_DEPTH:1] vld_reg;
    meta_t           meta_reg [1:PIPE_DEPTH];

    // Output register
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic               adv, s_acc;
    logic [1:0]         in_bank, in_color;
    logic [FIELD_W-1:0] in_amp, in_off;
    logic               in_emit;
    logic [13:0]        chk_sum;
    err_t               in_err;
    logic [7:0]         rem_sum;
    logic [15:0]        bank_ang, inner_ang;
    logic signed [15:0] s1;
    logic [FIELD_W-1:0] lane_level [4];
    meta_t              out_meta;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = !iss_vld_reg || (adv && iss_reg.last);
    assign s_acc    = s_tvalid && s_tready;

    // Input field decode
    assign in_bank  = s_tdata[1:0];
    assign in_color = s_tdata[3:2];
    assign in_amp   = s_tdata[15:4];
    assign in_off   = s_tdata[27:16];
    assign in_emit  = s_tdata[28];

    // Write check
    assign chk_sum = {1'b0, in_amp, 1'b0} + {2'b0, in_off};
    always_comb begin
        priority if (chk_sum > {2'b0, max_level_reg}) in_err = ERR_HIGH;
        else if (in_off < min_level_reg)              in_err = ERR_LOW;
        else                                          in_err = ERR_OK;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_level_reg <= '1;
            min_level_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_LEVEL: max_level_reg <= cfg_wdata;
                CFG_MIN_LEVEL: min_level_reg <= cfg_wdata;
            endcase
        end
    end

    // Counter advance on each accepted tick; phase tracks count*4096/125 mod 2^16
    assign rem_sum = {1'b0, ph_rem_reg} + {1'b0, PH_REM_STEP};
    always_comb begin
        tick_cnt_next = tick_cnt_reg;
        ph_q_next     = ph_q_reg;
        ph_rem_next   = ph_rem_reg;
        if (s_acc && s_tuser == OP_TICK) begin
            priority if (tick_cnt_reg == TICK_LAST) begin
                tick_cnt_next = '0;
                ph_q_next     = '0;
                ph_rem_next   = '0;
            end else if (rem_sum >= {1'b0, PH_DEN}) begin
                tick_cnt_next = 18'(tick_cnt_reg + 18'd1);
                ph_q_next     = 16'(ph_q_reg + PH_STEP + 16'd1);
                ph_rem_next   = 7'(rem_sum - {1'b0, PH_DEN});
            end else begin
                tick_cnt_next = 18'(tick_cnt_reg + 18'd1);
                ph_q_next     = 16'(ph_q_reg + PH_STEP);
                ph_rem_next   = rem_sum[6:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_cnt_reg <= '0;
            ph_q_reg     <= '0;
            ph_rem_reg   <= '0;
        end else begin
            tick_cnt_reg <= tick_cnt_next;
            ph_q_reg     <= ph_q_next;
            ph_rem_reg   <= ph_rem_next;
        end
    end

    // Issue sequencer: one write, or one bank per cycle for an emitting tick while not stalled
    always_comb begin
        iss_vld_next = iss_vld_reg;
        iss_next     = iss_reg;
        if (adv && iss_vld_reg) begin
            if (iss_reg.last) begin
                iss_vld_next = 1'b0;
            end else begin
                iss_next.bank = 2'(iss_reg.bank + 2'd1);
                iss_next.last = (2'(iss_reg.bank + 2'd1) == LAST_BANK);
            end
        end
        // A tick without emit only moves the counter and issues nothing
        if (s_acc) begin
            if (s_tuser == OP_WRITE) begin
                iss_vld_next   = 1'b1;
                iss_next.op    = OP_WRITE;
                iss_next.bank  = in_bank;
                iss_next.last  = 1'b1;
                iss_next.color = in_color;
                iss_next.amp   = in_amp;
                iss_next.off   = in_off;
                iss_next.err   = in_err;
                iss_next.store = (in_err == ERR_OK);
            end else if (in_emit) begin
                iss_vld_next   = 1'b1;
                iss_next.op    = OP_TICK;
                iss_next.bank  = '0;
                iss_next.last  = (EMIT_BANKS == 1);
                iss_next.color = '0;
                iss_next.amp   = '0;
                iss_next.off   = '0;
                iss_next.err   = ERR_OK;
                iss_next.store = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_vld_reg <= 1'b0;
        end else begin
            iss_vld_reg <= iss_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_reg <= iss_next;
    end

    // Control pipeline alongside the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-1:1], iss_vld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            meta_reg[1] <= iss_reg;
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    // Inner sine shared by all colors of a bank
    assign bank_ang  = 16'(iss_reg.bank) * BANK_PHASE;
    assign inner_ang = ph_q_reg + bank_ang;

    lcw_sine u_inner (
        .aclk  (aclk),
        .en    (adv),
        .angle (inner_ang),
        .sine  (s1)
    );

    // Four color lanes
    for (genvar c = 0; c < 4; c++) begin : g_lane
        tab_t lane_tab;

        assign lane_tab.we   = vld_reg[TAB_STAGE] && (meta_reg[TAB_STAGE].op == OP_WRITE)
                               && meta_reg[TAB_STAGE].store
                               && (meta_reg[TAB_STAGE].color == 2'(c));
        assign lane_tab.bank = meta_reg[TAB_STAGE].bank;
        assign lane_tab.amp  = meta_reg[TAB_STAGE].amp;
        assign lane_tab.off  = meta_reg[TAB_STAGE].off;

        lcw_lane #(
            .BANKS      (BANKS),
            .LEVEL_BITS (LEVEL_BITS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .s1        (s1),
            .phase_off (color_phase(2'(c))),
            .tab       (lane_tab),
            .level     (lane_level[c])
        );
    end

    // Merge lane levels into one result transfer
    assign out_meta = meta_reg[PIPE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vld_reg[PIPE_DEPTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && vld_reg[PIPE_DEPTH]) begin
            m_tlast_reg <= out_meta.last;
            if (out_meta.op == OP_WRITE) begin
                m_tdata_reg <= {4'b0, out_meta.err, {(4*FIELD_W){1'b0}}, out_meta.bank};
            end else begin
                m_tdata_reg <= {4'b0, ERR_OK, lane_level[3], lane_level[2],
                                lane_level[1], lane_level[0], out_meta.bank};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef NO_ASSERTIONS
    // A new item only enters when the issue stage is empty or finishing its last bank
    a_issue_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && iss_vld_reg) |-> (iss_reg.last && adv))
        else $error("item accepted while issue stage busy");

    // Tick banks stay within the emitted range
    a_bank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (iss_vld_reg && iss_reg.op == OP_TICK) |-> (iss_reg.bank <= LAST_BANK))
        else $error("tick bank out of range");

    // A failed write result is final and carries zero levels
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[51:50] != ERR_OK)
        |-> (m_tlast_reg && m_tdata_reg[49:2] == '0))
        else $error("error result with levels or without last");

    // Counter and phase remainder stay in range
    a_tick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_cnt_reg < TICK_WRAP) && (ph_rem_reg < PH_DEN))
        else $error("tick counter or phase remainder out of range");
`endif

endmodule

// ===== rtl/lcw_sine.sv =====
// Five-stage pipelined Q1.15 sine of a 16-bit turn-fraction angle.
module lcw_sine import lcw_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [15:0] sine
);

    logic [14:0] a_x_reg, b_x_reg, b_x2_reg, c_x2_reg, c_x3_reg, d_x5_reg;
    logic [29:0] b_pa_reg, c_pa_reg, d_pd_reg;
    logic        a_neg_reg, b_neg_reg, c_neg_reg, d_neg_reg;
    logic [15:0] sine_reg;

    logic [14:0] x_next;
    logic [29:0] sq_full, cu_full, fi_full, pn_full;
    logic [30:0] pa_full;
    logic [26:0] p5_full;
    logic [30:0] sum_full;
    logic [16:0] y_full;
    logic [14:0] y_clip;
    logic [15:0] sine_next;

    // Fold the angle into the first quadrant
    assign x_next = angle[14] ? 15'(QTR - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};

    // Odd powers and their coefficient products, spread across the pipeline stages
    assign sq_full  = 30'(a_x_reg) * 30'(a_x_reg);
    assign pa_full  = 31'(a_x_reg) * 31'(SIN_C1);
    assign cu_full  = 30'(b_x2_reg) * 30'(b_x_reg);
    assign fi_full  = 30'(c_x3_reg) * 30'(c_x2_reg);
    assign pn_full  = 30'(c_x3_reg) * 30'(SIN_C3);
    assign p5_full  = 27'(d_x5_reg) * 27'(SIN_C5);

    // Final sum, scale, clip and sign
    assign sum_full  = {1'b0, d_pd_reg} + {4'b0, p5_full};
    assign y_full    = sum_full[30:14];
    assign y_clip    = (y_full > {2'b0, Q15_MAX}) ? Q15_MAX : y_full[14:0];
    assign sine_next = d_neg_reg ? 16'(16'd0 - {1'b0, y_clip}) : {1'b0, y_clip};

    always_ff @(posedge aclk) begin
        if (en) begin
            a_x_reg   <= x_next;
            a_neg_reg <= angle[15];
            b_x_reg   <= a_x_reg;
            b_x2_reg  <= sq_full[28:14];
            b_pa_reg  <= pa_full[29:0];
            b_neg_reg <= a_neg_reg;
            c_x2_reg  <= b_x2_reg;
            c_x3_reg  <= cu_full[28:14];
            c_pa_reg  <= b_pa_reg;
            c_neg_reg <= b_neg_reg;
            d_x5_reg  <= fi_full[28:14];
            d_pd_reg  <= c_pa_reg - pn_full;
            d_neg_reg <= c_neg_reg;
            sine_reg  <= sine_next;
        end
    end

    assign sine = $signed(sine_reg);

endmodule

// ===== rtl/lcw_lane.sv =====
// One color lane: outer sine, per-bank amplitude/offset table and level scaling.
module lcw_lane import lcw_pkg::*; #(
    parameter int BANKS      = BANKS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic signed [15:0]  s1,
    input  logic [15:0]         phase_off,
    input  tab_t                tab,
    output logic [FIELD_W-1:0]  level
);

    localparam int DEPTH = (BANKS < MAX_RESULTS) ? BANKS : MAX_RESULTS;
    localparam int AW    = (LEVEL_BITS < FIELD_W) ? LEVEL_BITS : FIELD_W;
    localparam int SAT_W = (LEVEL_BITS < 14) ? LEVEL_BITS : 14;
    localparam logic [13:0] SAT_MAX = 14'((32'd1 << SAT_W) - 32'd1);

    logic [AW-1:0]      amp_tab_reg [DEPTH];
    logic [AW-1:0]      off_tab_reg [DEPTH];
    logic [12:0]        prod_reg;
    logic [FIELD_W-1:0] off_reg;

    logic [15:0]        outer_ang;
    logic signed [15:0] s2;
    logic [AW-1:0]      rd_amp, rd_off;
    logic [15:0]        bias;
    logic [27:0]        prod_full;
    logic [13:0]        sum;
    logic [13:0]        sat;

    // Outer angle: inner sine plus color phase, modulo one turn
    assign outer_ang = $unsigned(s1) + phase_off;

    lcw_sine u_sine (
        .aclk  (aclk),
        .en    (en),
        .angle (outer_ang),
        .sine  (s2)
    );

    // Table entry write, cleared to zero by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < DEPTH; e++) begin
                amp_tab_reg[e] <= '0;
                off_tab_reg[e] <= '0;
            end
        end else if (en && tab.we) begin
            for (int e = 0; e < DEPTH; e++) begin
                if (tab.bank == 2'(e)) begin
                    amp_tab_reg[e] <= tab.amp[AW-1:0];
                    off_tab_reg[e] <= tab.off[AW-1:0];
                end
            end
        end
    end

    // Table read for the bank at the table stage
    always_comb begin
        rd_amp = '0;
        rd_off = '0;
        for (int e = 0; e < DEPTH; e++) begin
            if (tab.bank == 2'(e)) begin
                rd_amp = amp_tab_reg[e];
                rd_off = off_tab_reg[e];
            end
        end
    end

    // amp * (32768 + s2): the bias is s2 with its sign bit flipped
    assign bias      = {~s2[15], s2[14:0]};
    assign prod_full = 28'(rd_amp) * 28'(bias);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_full[27:15];
            off_reg  <= FIELD_W'(rd_off);
        end
    end

    // Add offset and saturate to the level range
    assign sum   = {1'b0, prod_reg} + {2'b0, off_reg};
    assign sat   = (sum > SAT_MAX) ? SAT_MAX : sum;
    assign level = sat[FIELD_W-1:0];

endmodule
